// ===== rtl/escc_pkg.sv =====
// ---------------------------------------------------------------------------
// Edge stream component counter package
// Shared widths, token types and controller states for the label chain.
// ---------------------------------------------------------------------------
package escc_pkg;

    // Fixed field widths of the stream and configuration beats.
    localparam int END_W    = 8;
    localparam int CNT_W    = 9;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Default table size and the vertex count after reset.
    localparam int MAX_VERTICES_DEF = 256;
    localparam int VC_RESET         = 256;

    // What a token asks of each cell it passes.
    typedef enum logic {
        OP_LOOKUP  = 1'b0,
        OP_RELABEL = 1'b1
    } t_tok_op;

    // Control part of a token traveling down the cell chain.
    typedef struct packed {
        logic    valid;
        t_tok_op op;
    } t_tok_ctl;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RELABEL,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/escc_cell.sv =====
// ---------------------------------------------------------------------------
// Label cell
// Holds the component label of one vertex. A lookup token picks up the label
// when its endpoint matches this vertex; a relabel token rewrites the label
// when it matches the label being retired. The token moves on one cell per
// cycle.
// ---------------------------------------------------------------------------
module escc_cell #(
    parameter int LBL_W = 8,
    parameter int INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  escc_pkg::t_tok_ctl  i_ctl,
    input  logic [LBL_W-1:0]    i_a,
    input  logic [LBL_W-1:0]    i_b,
    input  logic [LBL_W-1:0]    i_keep,
    input  logic [LBL_W-1:0]    i_gone,
    output escc_pkg::t_tok_ctl  o_ctl,
    output logic [LBL_W-1:0]    o_a,
    output logic [LBL_W-1:0]    o_b,
    output logic [LBL_W-1:0]    o_keep,
    output logic [LBL_W-1:0]    o_gone
);

    localparam logic [LBL_W-1:0] MY_INDEX = LBL_W'(INDEX);

    logic [LBL_W-1:0]   r_label;
    logic [LBL_W-1:0]   n_label;
    escc_pkg::t_tok_ctl r_ctl;
    logic [LBL_W-1:0]   r_a;
    logic [LBL_W-1:0]   r_b;
    logic [LBL_W-1:0]   r_keep;
    logic [LBL_W-1:0]   n_keep;
    logic [LBL_W-1:0]   r_gone;
    logic [LBL_W-1:0]   n_gone;

    // Lookup captures this label into the token; relabel updates the label.
    always_comb begin
        n_label = r_label;
        n_keep  = i_keep;
        n_gone  = i_gone;
        if (i_ctl.valid && i_ctl.op == escc_pkg::OP_LOOKUP) begin
            if (i_a == MY_INDEX) begin
                n_keep = r_label;
            end
            if (i_b == MY_INDEX) begin
                n_gone = r_label;
            end
        end
        if (i_ctl.valid && i_ctl.op == escc_pkg::OP_RELABEL && r_label == i_gone) begin
            n_label = i_keep;
        end
    end

    // Label and token control start clean after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label   <= MY_INDEX;
            r_ctl     <= '{valid: 1'b0, op: escc_pkg::OP_LOOKUP};
        end else begin
            r_label   <= n_label;
            r_ctl     <= i_ctl;
        end
    end

    // Token payload passes to the next cell.
    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_b    <= i_b;
        r_keep <= n_keep;
        r_gone <= n_gone;
    end

    assign o_ctl  = r_ctl;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_keep = r_keep;
    assign o_gone = r_gone;

endmodule

// ===== rtl/edge_stream_component_counter_unit.sv =====
// ---------------------------------------------------------------------------
// Edge stream component counter
// Quick-find connected component count over a stream of edges. Each vertex
// label lives in its own cell of a chain; lookups and relabels travel down
// the chain as tokens.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s         in         one edge: end_a, end_b
//  m         out        one result: component_count, bad_vertex, merged
//  cfg       in         vertex total
//
// A bad edge goes straight to the done state. A valid edge sends a lookup token down
// the chain of MAX_VERTICES cells; a merging edge then sends a relabel token down the
// chain too.
// Reset is synchronous and restores every label to its own vertex number.
// A stalled result waits in the output register; the next edge is taken while it
// waits, and finishing that edge holds until the register is free.
module edge_stream_component_counter_unit #(
    parameter int MAX_VERTICES = escc_pkg::MAX_VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Edge input beat.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [escc_pkg::S_DATA_W-1:0] i_s_tdata,   // end_a[7:0], end_b[15:8]
    // Result output beat.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [escc_pkg::M_DATA_W-1:0] o_m_tdata,   // component_count[8:0],
                                                       // bad_vertex[9], merged[10],
                                                       // zero[15:11]
    // Vertex count write.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [escc_pkg::CNT_W-1:0]    i_cfg_data   // num_verts[8:0]
);

    localparam int LBL_W = $clog2(MAX_VERTICES);
    localparam int MRG_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = escc_pkg::CNT_W;
    localparam int END_W = escc_pkg::END_W;

    escc_pkg::t_state       r_state;
    escc_pkg::t_state       n_state;
    logic [CNT_W-1:0]       r_vc;
    logic [MRG_W-1:0]       r_merge;
    logic                   r_bad;
    logic                   r_merged;

    // Token injected at the head of the chain.
    escc_pkg::t_tok_ctl     r_inj_ctl;
    logic [LBL_W-1:0]       r_inj_a;
    logic [LBL_W-1:0]       r_inj_b;
    logic [LBL_W-1:0]       r_inj_keep;
    logic [LBL_W-1:0]       r_inj_gone;

    // Output register.
    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_bad;
    logic                   r_out_merged;

    // Links between cells; link k feeds cell k.
    escc_pkg::t_tok_ctl     link_ctl  [0:MAX_VERTICES];
    logic [LBL_W-1:0]       link_a    [0:MAX_VERTICES];
    logic [LBL_W-1:0]       link_b    [0:MAX_VERTICES];
    logic [LBL_W-1:0]       link_keep [0:MAX_VERTICES];
    logic [LBL_W-1:0]       link_gone [0:MAX_VERTICES];

    logic [END_W-1:0]       w_end_a;
    logic [END_W-1:0]       w_end_b;
    logic [CNT_W-1:0]       w_n;
    logic [CNT_W-1:0]       w_count;
    logic                   w_in_bad;
    logic                   w_accept;
    logic                   w_end_valid;
    logic                   w_labels_differ;
    logic                   w_s_ready;
    logic                   w_load_out;
    logic                   w_start_lookup;
    logic                   w_start_relabel;
    logic                   w_lookup_same;
    logic                   w_relabel_done;

    assign w_end_a = i_s_tdata[END_W-1:0];
    assign w_end_b = i_s_tdata[2*END_W-1:END_W];

    // Effective vertex count: clamp the register to 1..MAX_VERTICES.
    always_comb begin
        if (r_vc == '0) begin
            w_n = CNT_W'(1);
        end else if (int'(r_vc) > MAX_VERTICES) begin
            w_n = CNT_W'(MAX_VERTICES);
        end else begin
            w_n = r_vc;
        end
    end

    // Running count saturates at zero if the count was lowered mid-stream.
    always_comb begin
        if (int'(r_merge) >= int'(w_n)) begin
            w_count = '0;
        end else begin
            w_count = w_n - CNT_W'(r_merge);
        end
    end

    assign w_in_bad = (CNT_W'(w_end_a) >= w_n) || (CNT_W'(w_end_b) >= w_n);

    // Token coming back from the tail of the chain.
    assign w_end_valid     = link_ctl[MAX_VERTICES].valid;
    assign w_labels_differ = link_keep[MAX_VERTICES] != link_gone[MAX_VERTICES];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            escc_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = w_in_bad ? escc_pkg::ST_DONE : escc_pkg::ST_LOOKUP;
                end
            end
            escc_pkg::ST_LOOKUP: begin
                if (w_end_valid) begin
                    n_state = w_labels_differ ? escc_pkg::ST_RELABEL : escc_pkg::ST_DONE;
                end
            end
            escc_pkg::ST_RELABEL: begin
                if (w_end_valid) begin
                    n_state = escc_pkg::ST_DONE;
                end
            end
            escc_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = escc_pkg::ST_IDLE;
                end
            end
            default: n_state = escc_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        w_s_ready       = 1'b0;
        w_load_out      = 1'b0;
        w_lookup_same   = 1'b0;
        w_start_relabel = 1'b0;
        w_relabel_done  = 1'b0;
        unique case (r_state)
            escc_pkg::ST_IDLE:    w_s_ready = 1'b1;
            escc_pkg::ST_LOOKUP: begin
                w_start_relabel = w_end_valid && w_labels_differ;
                w_lookup_same   = w_end_valid && !w_labels_differ;
            end
            escc_pkg::ST_RELABEL: w_relabel_done = w_end_valid;
            escc_pkg::ST_DONE:    w_load_out = !r_out_valid || i_m_tready;
            default:              w_s_ready = 1'b0;
        endcase
    end

    assign w_accept       = i_s_tvalid && w_s_ready;
    assign w_start_lookup = w_accept && !w_in_bad;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= escc_pkg::ST_IDLE;
            r_vc        <= CNT_W'(escc_pkg::VC_RESET);
            r_merge     <= '0;
            r_inj_ctl   <= '{valid: 1'b0, op: escc_pkg::OP_LOOKUP};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            if (w_relabel_done) begin
                r_merge <= r_merge + MRG_W'(1);
            end
            if (w_start_lookup) begin
                r_inj_ctl <= '{valid: 1'b1, op: escc_pkg::OP_LOOKUP};
            end else if (w_start_relabel) begin
                r_inj_ctl <= '{valid: 1'b1, op: escc_pkg::OP_RELABEL};
            end else begin
                r_inj_ctl <= '{valid: 1'b0, op: escc_pkg::OP_LOOKUP};
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Edge payload, token payload and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_inj_a    <= LBL_W'(w_end_a);
            r_inj_b    <= LBL_W'(w_end_b);
            r_inj_keep <= '0;
            r_inj_gone <= '0;
            r_bad      <= w_in_bad;
            r_merged   <= 1'b0;
        end
        if (w_start_relabel) begin
            r_inj_keep <= link_keep[MAX_VERTICES];
            r_inj_gone <= link_gone[MAX_VERTICES];
        end
        if (w_lookup_same) begin
            r_merged <= 1'b0;
        end
        if (w_relabel_done) begin
            r_merged <= 1'b1;
        end
        if (w_load_out) begin
            r_out_count  <= w_count;
            r_out_bad    <= r_bad;
            r_out_merged <= r_merged;
        end
    end

    // Head of the chain.
    assign link_ctl[0]  = r_inj_ctl;
    assign link_a[0]    = r_inj_a;
    assign link_b[0]    = r_inj_b;
    assign link_keep[0] = r_inj_keep;
    assign link_gone[0] = r_inj_gone;

    // One cell per vertex.
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        escc_cell #(
            .LBL_W (LBL_W),
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (link_ctl[k]),
            .i_a     (link_a[k]),
            .i_b     (link_b[k]),
            .i_keep  (link_keep[k]),
            .i_gone  (link_gone[k]),
            .o_ctl   (link_ctl[k+1]),
            .o_a     (link_a[k+1]),
            .o_b     (link_b[k+1]),
            .o_keep  (link_keep[k+1]),
            .o_gone  (link_gone[k+1])
        );
    end

    // Ports.
    assign o_s_tready  = w_s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {(escc_pkg::M_DATA_W - CNT_W - 2)'(0),
                          r_out_merged, r_out_bad, r_out_count};

    // A result never reports both a rejected edge and a merge.
    a_bad_not_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_bad && r_out_merged))
        else $error("result flags both a bad endpoint and a merge");

    // A token leaves the chain only while the controller waits for one.
    a_token_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_valid |-> (r_state == escc_pkg::ST_LOOKUP || r_state == escc_pkg::ST_RELABEL))
        else $error("token returned from the chain unexpectedly");

    // The endpoints come back through the chain as they went in.
    a_token_intact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_valid |-> (link_a[MAX_VERTICES] == r_inj_a && link_b[MAX_VERTICES] == r_inj_b))
        else $error("token endpoints corrupted in the chain");

    // The merge total can never pass the number of vertices less one.
    a_merge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_relabel_done |-> (int'(r_merge) < MAX_VERTICES - 1))
        else $error("merge total overflow");

endmodule
